[rtl/core/dirac_coin_spinor_apply_macros.svh]
// ----------------------------------------------------------------------------
// dirac_coin_spinor_apply_macros.svh
// assertion macros for the checker of the coin block
// ----------------------------------------------------------------------------
`ifndef DIRAC_COIN_SPINOR_APPLY_MACROS_SVH
`define DIRAC_COIN_SPINOR_APPLY_MACROS_SVH

// clocked check, quiet while rst is high
`define DCSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs through reset
`define DCSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/dcsa_pkg.sv]
// ----------------------------------------------------------------------------
// dcsa_pkg
// widths, register codes and rounding helper for the dirac coin block
// ----------------------------------------------------------------------------
package dcsa_pkg;

  localparam int DataW    = 16;
  localparam int NumComp  = 4;
  localparam int NumDir   = 3;
  localparam int InDataW  = (NumDir + 2 * NumComp) * DataW;
  localparam int OutDataW = 2 * NumComp * DataW;
  localparam int SpinorLo = NumDir * DataW;
  localparam int CfgIdxW  = 8;

  // product and accumulator widths
  localparam int ProdW  = 2 * DataW;
  localparam int SumW   = ProdW + 1;
  localparam int ScaleW = SumW + DataW;
  localparam int AccW   = ScaleW + 1;

  localparam int AlignShift = 14;
  localparam int RoundShift = 28;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegCos = 8'd0;
  localparam logic [CfgIdxW-1:0] RegSin = 8'd1;

  typedef logic signed [DataW-1:0]  samp_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [ScaleW-1:0] scale_t;
  typedef logic signed [AccW-1:0]   acc_t;

  localparam samp_t CosReset = 16'sd14378;
  localparam samp_t SinReset = 16'sd7855;

  localparam acc_t RoundBias = acc_t'(1) <<< (RoundShift - 1);
  localparam acc_t SatHi     = acc_t'(32767);
  localparam acc_t SatLo     = -acc_t'(32768);

  // round half up at bit RoundShift, then clamp to q1.15
  function automatic samp_t sat_round(input acc_t acc);
    acc_t r;
    r = (acc + RoundBias) >>> RoundShift;
    if (r > SatHi) begin
      sat_round = samp_t'(SatHi);
    end else if (r < SatLo) begin
      sat_round = samp_t'(SatLo);
    end else begin
      sat_round = r[DataW-1:0];
    end
  endfunction

endpackage

[rtl/core/dirac_coin_spinor_apply.sv]
// ----------------------------------------------------------------------------
// dirac_coin_spinor_apply
// four-stage pipeline applying the dirac walk coin to one spinor per request
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one site: direction vector and spinor in tdata, the face
//   flag in tuser. with the flag set the result is
//   cos_theta*p - i*sin_theta*(d.alpha)p, rounded and saturated to q1.15;
//   with the flag clear the spinor comes out untouched.
//   m_axis carries the result spinor, one result request per input request.
//   cfg writes cos_theta (index 0) or sin_theta (index 1), q2.14; other
//   indexes are dropped. cfg_ready is always high. write only while idle.
// timing
//   four register stages: products, alpha sums, sine scaling, round/output.
//   a request passes products, alpha sums, sine scaling and the output
//   register in order before m_axis; one request per cycle while m_axis is not held.
// reset / stall
//   rst clears all stage valid bits and reloads cos/sin (cos(0.5), sin(0.5)).
//   each stage advances when it is empty or the stage after it advances,
//   so a stalled sink lets bubbles close up before s_axis_tready drops.
// ----------------------------------------------------------------------------
module dirac_coin_spinor_apply
  import dcsa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input spinor
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // dir_x, dir_y, dir_z, in0_re, in0_im, in1_re, in1_im, in2_re, in2_im,
  // in3_re, in3_im
  input  logic [InDataW-1:0]  s_axis_tdata,
  // face_valid
  input  logic [0:0]          s_axis_tuser,
  // result spinor
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out0_re, out0_im, out1_re, out1_im, out2_re, out2_im, out3_re, out3_im
  output logic [OutDataW-1:0] m_axis_tdata,
  // register writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [DataW-1:0]    cfg_data
);

  // coin registers
  samp_t cos_theta;
  samp_t sin_theta;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_theta <= CosReset;
      sin_theta <= SinReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegCos:  cos_theta <= cfg_data;
        RegSin:  sin_theta <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valid bits and advance enables
  logic v1, v2, v3, v4;
  logic load1, load2, load3, load4;

  assign load4 = !v4 || m_axis_tready;
  assign load3 = !v3 || load4;
  assign load2 = !v2 || load3;
  assign load1 = !v1 || load2;

  assign s_axis_tready = load1;
  assign m_axis_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (load1) v1 <= s_axis_tvalid;
      if (load2) v2 <= v1;
      if (load3) v3 <= v2;
      if (load4) v4 <= v3;
    end
  end

  // input unpacking
  samp_t dir_x, dir_y, dir_z;
  samp_t p_re [NumComp];
  samp_t p_im [NumComp];

  assign dir_x = s_axis_tdata[0 * DataW +: DataW];
  assign dir_y = s_axis_tdata[1 * DataW +: DataW];
  assign dir_z = s_axis_tdata[2 * DataW +: DataW];

  // flag and raw spinor ride along for pass-through
  logic                face1, face2, face3;
  logic [OutDataW-1:0] raw1, raw2, raw3;
  logic [OutDataW-1:0] out_data;

  // rounded coin result per component, ahead of the output register
  samp_t res_re [NumComp];
  samp_t res_im [NumComp];

  always_ff @(posedge clk) begin
    if (load1) begin
      face1 <= s_axis_tuser[0];
      raw1  <= s_axis_tdata[SpinorLo +: OutDataW];
    end
    if (load2) begin
      face2 <= face1;
      raw2  <= raw1;
    end
    if (load3) begin
      face3 <= face2;
      raw3  <= raw2;
    end
  end

  assign m_axis_tdata = out_data;

  for (genvar k = 0; k < NumComp; k++) begin : g_comp
    // component k pairs z with p[k^2] and the x/y term with p[k^3]
    localparam int Zs = k ^ 2;
    localparam int Xs = k ^ 3;

    // stage 1: exact 16x16 products
    prod_t zr1, zi1, xr1, xi1, yr1, yi1;
    prod_t cr1, ci1;
    // stage 2: alpha sums and the cosine term carried along
    sum_t  er2, ei2;
    prod_t cr2, ci2;
    sum_t  er_sum, ei_sum;
    // stage 3: sine scaling
    scale_t sr3, si3;
    prod_t  cr3, ci3;
    // stage 4 combinational
    acc_t  acc_re, acc_im;

    assign p_re[k] = s_axis_tdata[(NumDir + 2 * k) * DataW +: DataW];
    assign p_im[k] = s_axis_tdata[(NumDir + 2 * k + 1) * DataW +: DataW];

    always_ff @(posedge clk) begin
      if (load1) begin
        zr1 <= dir_z * p_re[Zs];
        zi1 <= dir_z * p_im[Zs];
        xr1 <= dir_x * p_re[Xs];
        xi1 <= dir_x * p_im[Xs];
        yr1 <= dir_y * p_re[Xs];
        yi1 <= dir_y * p_im[Xs];
        cr1 <= cos_theta * p_re[k];
        ci1 <= cos_theta * p_im[k];
      end
    end

    // even rows: z*p + (x - iy)*p'; odd rows: (x + iy)*p' - z*p
    if ((k % 2) == 0) begin : g_even
      assign er_sum = sum_t'(zr1) + sum_t'(xr1) + sum_t'(yi1);
      assign ei_sum = sum_t'(zi1) + sum_t'(xi1) - sum_t'(yr1);
    end else begin : g_odd
      assign er_sum = sum_t'(xr1) - sum_t'(yi1) - sum_t'(zr1);
      assign ei_sum = sum_t'(xi1) + sum_t'(yr1) - sum_t'(zi1);
    end

    always_ff @(posedge clk) begin
      if (load2) begin
        er2 <= er_sum;
        ei2 <= ei_sum;
        cr2 <= cr1;
        ci2 <= ci1;
      end
      if (load3) begin
        sr3 <= sin_theta * ei2;
        si3 <= sin_theta * er2;
        cr3 <= cr2;
        ci3 <= ci2;
      end
    end

    // -i*sin*E: real gains sin*Im(E), imaginary loses sin*Re(E)
    assign acc_re = (acc_t'(cr3) <<< AlignShift) + acc_t'(sr3);
    assign acc_im = (acc_t'(ci3) <<< AlignShift) - acc_t'(si3);

    assign res_re[k] = sat_round(acc_re);
    assign res_im[k] = sat_round(acc_im);
  end

  // output register: coin result or the untouched spinor
  always_ff @(posedge clk) begin
    if (load4) begin
      for (int c = 0; c < NumComp; c++) begin
        if (face3) begin
          out_data[(2 * c) * DataW +: DataW]     <= res_re[c];
          out_data[(2 * c + 1) * DataW +: DataW] <= res_im[c];
        end else begin
          out_data[(2 * c) * DataW +: DataW]     <= raw3[(2 * c) * DataW +: DataW];
          out_data[(2 * c + 1) * DataW +: DataW] <= raw3[(2 * c + 1) * DataW +: DataW];
        end
      end
    end
  end

endmodule

[rtl/core/dcsa_checker.sv]
// ----------------------------------------------------------------------------
// dcsa_checker
// port-level checks for the dirac coin pipeline, bound to the top level
// ----------------------------------------------------------------------------
`include "dirac_coin_spinor_apply_macros.svh"

module dcsa_checker
  import dcsa_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic [0:0]          s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // pipeline comes out of reset empty
  `DCSA_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "output valid after reset")

  // a stalled result holds
  `DCSA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // input backs up only behind a held output
  `DCSA_ASSERT(a_ready_cause, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled with output free")

  // pass-through request shows up unchanged on an open sink
  `DCSA_ASSERT(a_pass_latency, (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0]) ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid && (m_axis_tdata == $past(s_axis_tdata[SpinorLo +: OutDataW], 4)), "pass-through result wrong or late")

endmodule

bind dirac_coin_spinor_apply dcsa_checker u_dcsa_checker (.*);

[test/tb_coin_pkg.sv]
// ----------------------------------------------------------------------------
// tb_coin_pkg
// site and spinor records plus the coin predictor and result checker
// ----------------------------------------------------------------------------
package tb_coin_pkg;

  import dcsa_pkg::*;

  // one site as offered on the input stream
  typedef struct {
    bit    face;
    samp_t dir [NumDir];
    samp_t re  [NumComp];
    samp_t im  [NumComp];
  } site_t;

  // one result spinor
  typedef struct {
    samp_t re [NumComp];
    samp_t im [NumComp];
  } spinor_t;

  class coin_check;

    samp_t   cos_q;
    samp_t   sin_q;
    spinor_t expected_spinors [$];
    int      fails;

    function new();
      cos_q = CosReset;
      sin_q = SinReset;
      fails = 0;
    endfunction

    // unknown indexes are dropped, as in the block
    function void set_reg(logic [CfgIdxW-1:0] idx, samp_t val);
      if (idx == RegCos) begin
        cos_q = val;
      end else if (idx == RegSin) begin
        sin_q = val;
      end
    endfunction

    // round half up at 2^-15, then clamp
    function samp_t round_q15(longint acc);
      longint r;
      r = (acc + (longint'(1) <<< (RoundShift - 1))) >>> RoundShift;
      if (r > 32767) begin
        return 16'sh7fff;
      end else if (r < -32768) begin
        return 16'sh8000;
      end
      return samp_t'(r);
    endfunction

    function spinor_t predict_spinor(site_t s);
      longint  x, y, z, c, sn;
      longint  p_re [NumComp];
      longint  p_im [NumComp];
      longint  e_re [NumComp];
      longint  e_im [NumComp];
      spinor_t o;
      if (!s.face) begin
        o.re = s.re;
        o.im = s.im;
        return o;
      end
      x  = longint'(s.dir[0]);
      y  = longint'(s.dir[1]);
      z  = longint'(s.dir[2]);
      c  = longint'(cos_q);
      sn = longint'(sin_q);
      for (int k = 0; k < NumComp; k++) begin
        p_re[k] = longint'(s.re[k]);
        p_im[k] = longint'(s.im[k]);
      end
      // upper pair from the lower half of the spinor and vice versa
      e_re[0] = z * p_re[2] + x * p_re[3] + y * p_im[3];
      e_im[0] = z * p_im[2] + x * p_im[3] - y * p_re[3];
      e_re[1] = x * p_re[2] - y * p_im[2] - z * p_re[3];
      e_im[1] = x * p_im[2] + y * p_re[2] - z * p_im[3];
      e_re[2] = z * p_re[0] + x * p_re[1] + y * p_im[1];
      e_im[2] = z * p_im[0] + x * p_im[1] - y * p_re[1];
      e_re[3] = x * p_re[0] - y * p_im[0] - z * p_re[1];
      e_im[3] = x * p_im[0] + y * p_re[0] - z * p_im[1];
      for (int k = 0; k < NumComp; k++) begin
        o.re[k] = round_q15(((c * p_re[k]) <<< AlignShift) + sn * e_im[k]);
        o.im[k] = round_q15(((c * p_im[k]) <<< AlignShift) - sn * e_re[k]);
      end
      return o;
    endfunction

    function void note_site(site_t s);
      expected_spinors.push_back(predict_spinor(s));
    endfunction

    function void check_spinor(logic [OutDataW-1:0] d);
      spinor_t e;
      samp_t   got;
      if (expected_spinors.size() == 0) begin
        $error("result spinor with no site outstanding");
        fails++;
        return;
      end
      e = expected_spinors.pop_front();
      for (int k = 0; k < NumComp; k++) begin
        got = d[2 * k * DataW +: DataW];
        if (got !== e.re[k]) begin
          $error("out%0d_re: expected %0d, actual %0d", k, e.re[k], got);
          fails++;
        end
        got = d[(2 * k + 1) * DataW +: DataW];
        if (got !== e.im[k]) begin
          $error("out%0d_im: expected %0d, actual %0d", k, e.im[k], got);
          fails++;
        end
      end
    endfunction

    function int pending();
      return expected_spinors.size();
    endfunction

  endclass

endpackage

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// streams sites through the dirac coin block and checks every result spinor
// against a local predictor, across several cos/sin settings and with random
// gaps on the input side and stalls on the output side
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import dcsa_pkg::*;
  import tb_coin_pkg::*;

  localparam int PipeDepth    = 4;
  localparam int NumPhases    = 9;
  localparam int PhaseItems   = 200;
  localparam int NumDirected  = 20;
  localparam int HoldCycles   = 200;
  localparam int TimeoutNs    = 5_000_000;

  localparam samp_t MaxQ    = 16'sh7fff;
  localparam samp_t MinQ    = 16'sh8000;
  localparam samp_t Unit    = 16'sd16384;
  localparam samp_t NegUnit = -16'sd16384;

  // indexes the block has no register for
  localparam logic [CfgIdxW-1:0] RegUnused = 8'd2;
  localparam logic [CfgIdxW-1:0] RegTop    = 8'hff;

  typedef enum logic [1:0] {SinkOpen, SinkRandom, SinkPattern} sink_mode_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [0:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [DataW-1:0]    cfg_data;

  coin_check  board;
  sink_mode_t sink_mode;
  bit         hold_off;
  bit         sender_gaps;
  int         burst_left;

  dirac_coin_spinor_apply dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- stimulus

  // direction vector first, then the spinor re/im pairs, lowest bits up
  function automatic logic [InDataW-1:0] pack_site(site_t s);
    logic [InDataW-1:0] d;
    d = '0;
    for (int i = 0; i < NumDir; i++) begin
      d[i * DataW +: DataW] = s.dir[i];
    end
    for (int k = 0; k < NumComp; k++) begin
      d[SpinorLo + 2 * k * DataW +: DataW]       = s.re[k];
      d[SpinorLo + (2 * k + 1) * DataW +: DataW] = s.im[k];
    end
    return d;
  endfunction

  function automatic site_t fill_site(bit face, samp_t x, samp_t y, samp_t z, samp_t v);
    site_t s;
    s.face   = face;
    s.dir[0] = x;
    s.dir[1] = y;
    s.dir[2] = z;
    for (int k = 0; k < NumComp; k++) begin
      s.re[k] = v;
      s.im[k] = v;
    end
    return s;
  endfunction

  function automatic samp_t rand_q14();
    return samp_t'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  // mostly in range, now and then a raw pattern or an extreme
  function automatic samp_t rand_dir();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      return samp_t'($urandom);
    end else if (sel == 1) begin
      return ($urandom_range(0, 1) != 0) ? Unit : NegUnit;
    end
    return rand_q14();
  endfunction

  function automatic samp_t rand_amp();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      return ($urandom_range(0, 1) != 0) ? MaxQ : MinQ;
    end else if (sel == 1) begin
      return samp_t'(int'($urandom_range(0, 128)) - 64);
    end
    return samp_t'($urandom);
  endfunction

  function automatic site_t random_site();
    site_t s;
    int    axis;
    s.face = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 4) == 0) begin
      // unit vector along one axis, like a lattice face
      axis = $urandom_range(0, NumDir - 1);
      for (int i = 0; i < NumDir; i++) begin
        s.dir[i] = '0;
      end
      s.dir[axis] = ($urandom_range(0, 1) != 0) ? Unit : NegUnit;
    end else begin
      for (int i = 0; i < NumDir; i++) begin
        s.dir[i] = rand_dir();
      end
    end
    for (int k = 0; k < NumComp; k++) begin
      s.re[k] = rand_amp();
      s.im[k] = rand_amp();
    end
    return s;
  endfunction

  function automatic site_t directed_site(int n);
    site_t s;
    case (n)
      0: s = fill_site(1'b1, '0, '0, '0, '0);
      // flag clear: every bit must come through untouched
      1: begin
        s = fill_site(1'b0, MinQ, MaxQ, Unit, MaxQ);
        s.im[0] = MinQ;
        s.re[3] = 16'sd1;
      end
      2:  s = fill_site(1'b0, '0, '0, '0, MinQ);
      3:  s = fill_site(1'b1, Unit, '0, '0, MaxQ);
      4:  s = fill_site(1'b1, NegUnit, '0, '0, MinQ);
      5:  s = fill_site(1'b1, '0, Unit, '0, MaxQ);
      6:  s = fill_site(1'b1, '0, NegUnit, '0, MinQ);
      7:  s = fill_site(1'b1, '0, '0, Unit, MaxQ);
      8:  s = fill_site(1'b1, '0, '0, NegUnit, MinQ);
      // full-scale vectors push the sums into saturation
      9:  s = fill_site(1'b1, Unit, Unit, Unit, MaxQ);
      10: s = fill_site(1'b1, NegUnit, NegUnit, NegUnit, MinQ);
      // direction patterns outside the nominal range
      11: s = fill_site(1'b1, MaxQ, MaxQ, MaxQ, MinQ);
      12: s = fill_site(1'b1, MinQ, MinQ, MinQ, MaxQ);
      // tiny values where only the rounding decides
      13: s = fill_site(1'b1, '0, '0, '0, 16'sd1);
      14: s = fill_site(1'b1, '0, '0, '0, -16'sd1);
      15: s = fill_site(1'b1, 16'sd1, -16'sd1, 16'sd1, 16'sd2);
      16: begin
        s = fill_site(1'b1, Unit, '0, '0, '0);
        s.re[0] = MaxQ;
        s.im[3] = MinQ;
      end
      default: begin
        s = random_site();
        s.face = n[0];
      end
    endcase
    return s;
  endfunction

  // offer one site from a falling edge, return at the falling edge after it
  // was taken; valid stays high so back-to-back sites need no extra edge
  task automatic put_site(site_t s);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = pack_site(s);
    s_axis_tuser  = s.face;
    do @(posedge clk); while (!s_axis_tready);
    board.note_site(s);
    @(negedge clk);
  endtask

  // bursts of random length, with random gaps between them when sender_gaps is set
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (sender_gaps) begin
        gap = $urandom_range(1, 6);
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // stop sending and let every outstanding result come out
  task automatic drain();
    s_axis_tvalid = 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    repeat (2 * PipeDepth) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, samp_t val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
    @(negedge clk);
  endtask

  // coin angle per phase; phase 0 keeps the reset values
  task automatic program_phase(int phase);
    case (phase)
      1: begin
        write_reg(RegCos, Unit);
        write_reg(RegSin, '0);
      end
      2: begin
        write_reg(RegCos, '0);
        write_reg(RegSin, Unit);
      end
      3: begin
        write_reg(RegCos, NegUnit);
        write_reg(RegSin, NegUnit);
      end
      4: begin
        write_reg(RegCos, Unit);
        write_reg(RegSin, Unit);
      end
      // raw patterns beyond +-1.0
      5: begin
        write_reg(RegCos, MaxQ);
        write_reg(RegSin, MinQ);
      end
      // writes to unknown indexes must leave both registers alone
      6: begin
        write_reg(RegUnused, samp_t'($urandom));
        write_reg(RegTop, samp_t'($urandom));
      end
      0: ;
      default: begin
        write_reg(RegCos, rand_q14());
        write_reg(RegSin, rand_q14());
      end
    endcase
  endtask

  // ------------------------------------------------------------------ sink

  // ready pattern per mode, with a long hold-off on request
  initial begin
    int cyc;
    cyc = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_off) begin
        hold_off      = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        case (sink_mode)
          SinkOpen:    m_axis_tready = 1'b1;
          SinkRandom:  m_axis_tready = ($urandom_range(0, 3) != 0);
          default:     m_axis_tready = ((cyc % 7) > 2);
        endcase
      end
    end
  end

  // every result request taken goes to the checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_spinor(m_axis_tdata);
    end
  end

  // ------------------------------------------------------------- main flow

  initial begin
    board         = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = RegCos;
    cfg_data      = '0;
    sink_mode     = SinkOpen;
    hold_off      = 1'b0;
    sender_gaps   = 1'b0;
    burst_left    = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // corner cases back to back with reset coin angle
    for (int n = 0; n < NumDirected; n++) begin
      put_site(directed_site(n));
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain();
      program_phase(phase);
      sink_mode   = sink_mode_t'(phase % 3);
      // every fourth phase the sender never pauses
      sender_gaps = ((phase % 4) != 1);
      // long sink stall while sites keep coming, so the input backs up
      if (phase == 2) begin
        hold_off = 1'b1;
      end
      for (int i = 0; i < PhaseItems; i++) begin
        // sender waits for the pipe to empty in the middle of a phase
        if (phase == 4 && i == PhaseItems / 2) begin
          drain();
        end
        pace();
        put_site(random_site());
      end
    end

    s_axis_tvalid = 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    repeat (4 * PipeDepth) @(posedge clk);
    if (board.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TimeoutNs);
    $display("Test completed with failures");
    $finish;
  end

endmodule
